>>> rtl/srf_pkg.sv
`timescale 1ns / 1ps
// Shared definitions for the sample ring FIFO: defaults, operation codes and sequencer states.
// No dependencies; every other file of the block except srf_cfg_if imports this package.
package srf_pkg;

    localparam int STORE_DEPTH_DEF  = 1024;
    localparam int SAMPLE_WIDTH_DEF = 32;
    localparam int CAPACITY_RESET   = 1024;
    localparam int OP_WIDTH         = 3;

    typedef enum logic [OP_WIDTH-1:0] {
        OP_PUSH  = 3'd0,
        OP_FILL  = 3'd1,
        OP_POP   = 3'd2,
        OP_DROP  = 3'd3,
        OP_PEEK  = 3'd4,
        OP_CLEAR = 3'd5
    } srf_op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_WRITE,
        ST_RESULT
    } srf_state_t;

endpackage

>>> rtl/srf_req_if.sv
`timescale 1ns / 1ps
// Request channel of the sample ring FIFO: operation, sample word and amount.
// Depends on srf_pkg for the operation field width.
interface srf_req_if
    import srf_pkg::*;
#(
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
    parameter int COUNT_WIDTH  = 11
);
    logic                    valid;
    logic                    ready;
    logic [OP_WIDTH-1:0]     operation;
    logic [SAMPLE_WIDTH-1:0] sample_in;
    logic [COUNT_WIDTH-1:0]  amount;

    modport source (output valid, operation, sample_in, amount, input ready);
    modport sink   (input valid, operation, sample_in, amount, output ready);
endinterface

>>> rtl/srf_rsp_if.sv
`timescale 1ns / 1ps
// Result channel of the sample ring FIFO: sample word, occupancy, count done, empty flag.
// Depends on srf_pkg for default widths.
interface srf_rsp_if
    import srf_pkg::*;
#(
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
    parameter int COUNT_WIDTH  = 11
);
    logic                    valid;
    logic                    ready;
    logic [SAMPLE_WIDTH-1:0] sample_out;
    logic [COUNT_WIDTH-1:0]  occupancy;
    logic [COUNT_WIDTH-1:0]  amount_done;
    logic                    was_empty;

    modport source (output valid, sample_out, occupancy, amount_done, was_empty, input ready);
    modport sink   (input valid, sample_out, occupancy, amount_done, was_empty, output ready);
endinterface

>>> rtl/srf_cfg_if.sv
`timescale 1ns / 1ps
// Configuration write channel of the sample ring FIFO, carrying the capacity register.
// Depends on nothing but the widths handed down by the top level.
interface srf_cfg_if #(
    parameter int COUNT_WIDTH = 11
);
    logic                   valid;
    logic                   ready;
    logic [COUNT_WIDTH-1:0] capacity;

    modport source (output valid, capacity, input ready);
    modport sink   (input valid, capacity, output ready);
endinterface

>>> rtl/sample_ring_fifo.sv
`timescale 1ns / 1ps
// Top level of the sample ring FIFO: capacity register, sequencer and sample memory.
// Depends on srf_pkg, the three channel interfaces, srf_ctrl and srf_store.
//
//   Channel | Modport | Carries                                        | Accepted when
//   --------+---------+------------------------------------------------+---------------
//   req     | sink    | operation, sample_in, amount                   | valid && ready
//   rsp     | source  | sample_out, occupancy, amount_done, was_empty  | valid && ready
//   cfg     | sink    | capacity                                       | valid && ready
//
// Items are handled one at a time: each goes from the IDLE state through EXEC to RESULT,
// and push and fill pass through WRITE between EXEC and RESULT, writing their samples
// one per cycle through the single write port. The EXEC state waits out the registered
// memory read. Reset empties the FIFO, zeroes both pointers and loads the default
// capacity; memory contents are not cleared. A stalled result holds the output register;
// the next item is accepted and its result waits.
module sample_ring_fifo
    import srf_pkg::*;
#(
    parameter int STORE_DEPTH  = STORE_DEPTH_DEF,
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
    localparam int PTR_WIDTH   = $clog2(STORE_DEPTH),
    localparam int COUNT_WIDTH = $clog2(STORE_DEPTH + 1)
)
(
    input  logic      clk,
    input  logic      rst_n,
    srf_req_if.sink   req,
    srf_rsp_if.source rsp,
    srf_cfg_if.sink   cfg
);

    // The capacity register resets to the default, held within the memory depth.
    localparam int CAP_RESET_I = (CAPACITY_RESET < STORE_DEPTH) ? CAPACITY_RESET : STORE_DEPTH;
    localparam logic [COUNT_WIDTH-1:0] CAP_RESET = COUNT_WIDTH'(CAP_RESET_I);
    localparam logic [COUNT_WIDTH-1:0] DEPTH_C   = COUNT_WIDTH'(STORE_DEPTH);

    logic [COUNT_WIDTH-1:0]  capacity_reg, capacity_next;
    logic [COUNT_WIDTH-1:0]  cap_eff;

    logic                    wr_en;
    logic [PTR_WIDTH-1:0]    wr_addr;
    logic [SAMPLE_WIDTH-1:0] wr_data;
    logic                    rd_en;
    logic [PTR_WIDTH-1:0]    rd_addr;
    logic [SAMPLE_WIDTH-1:0] rd_data;

    // Configuration writes are taken unchecked; the user must send them only when idle.
    assign cfg.ready = 1'b1;

    always_comb
    begin
        capacity_next = capacity_reg;
        if (cfg.valid)
        begin
            capacity_next = cfg.capacity;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= CAP_RESET;
        end
        else
        begin
            capacity_reg <= capacity_next;
        end
    end

    // A capacity above the memory depth saturates at the depth. A capacity of zero
    // refuses all writes, and one lowered below the occupancy keeps the held samples.
    assign cap_eff = (capacity_reg > DEPTH_C) ? DEPTH_C : capacity_reg;

    srf_ctrl #(
        .STORE_DEPTH  (STORE_DEPTH),
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .cap_eff (cap_eff),
        .req     (req),
        .rsp     (rsp),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    srf_store #(
        .STORE_DEPTH  (STORE_DEPTH),
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

endmodule

>>> rtl/srf_store.sv
`timescale 1ns / 1ps
// Sample memory of the ring FIFO: one write port and one read port with registered data.
// Depends on srf_pkg for default sizes.
module srf_store
    import srf_pkg::*;
#(
    parameter int STORE_DEPTH  = STORE_DEPTH_DEF,
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
    localparam int PTR_WIDTH   = $clog2(STORE_DEPTH)
)
(
    input  logic                    clk,
    input  logic                    wr_en,
    input  logic [PTR_WIDTH-1:0]    wr_addr,
    input  logic [SAMPLE_WIDTH-1:0] wr_data,
    input  logic                    rd_en,
    input  logic [PTR_WIDTH-1:0]    rd_addr,
    output logic [SAMPLE_WIDTH-1:0] rd_data
);

    logic [SAMPLE_WIDTH-1:0] mem [STORE_DEPTH];
    logic [SAMPLE_WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> rtl/srf_ctrl.sv
`timescale 1ns / 1ps
// Sequencer of the ring FIFO: pointers, fill count, operation execution and result register.
// Depends on srf_pkg, srf_req_if and srf_rsp_if; drives the srf_store ports.
module srf_ctrl
    import srf_pkg::*;
#(
    parameter int STORE_DEPTH  = STORE_DEPTH_DEF,
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
    localparam int PTR_WIDTH   = $clog2(STORE_DEPTH),
    localparam int COUNT_WIDTH = $clog2(STORE_DEPTH + 1)
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic [COUNT_WIDTH-1:0]  cap_eff,
    srf_req_if.sink                 req,
    srf_rsp_if.source               rsp,
    output logic                    wr_en,
    output logic [PTR_WIDTH-1:0]    wr_addr,
    output logic [SAMPLE_WIDTH-1:0] wr_data,
    output logic                    rd_en,
    output logic [PTR_WIDTH-1:0]    rd_addr,
    input  logic [SAMPLE_WIDTH-1:0] rd_data
);

    localparam int SUM_WIDTH = COUNT_WIDTH + 1;
    localparam logic [COUNT_WIDTH-1:0] DEPTH_C = COUNT_WIDTH'(STORE_DEPTH);
    localparam logic [PTR_WIDTH-1:0]   PTR_LAST = PTR_WIDTH'(STORE_DEPTH - 1);
    localparam logic [SUM_WIDTH-1:0]   DEPTH_S = SUM_WIDTH'(STORE_DEPTH);

    srf_state_t state_reg, state_next;

    logic [OP_WIDTH-1:0]     op_reg, op_next;
    logic [SAMPLE_WIDTH-1:0] sample_reg, sample_next;
    logic [COUNT_WIDTH-1:0]  amount_reg, amount_next;
    logic [PTR_WIDTH-1:0]    rp_reg, rp_next;
    logic [PTR_WIDTH-1:0]    wp_reg, wp_next;
    logic [COUNT_WIDTH-1:0]  count_reg, count_next;
    logic [COUNT_WIDTH-1:0]  done_reg, done_next;
    logic [SAMPLE_WIDTH-1:0] result_reg, result_next;
    logic                    empty_reg, empty_next;

    logic                    rsp_valid_reg, rsp_valid_next;
    logic [SAMPLE_WIDTH-1:0] rsp_sample_reg, rsp_sample_next;
    logic [COUNT_WIDTH-1:0]  rsp_occ_reg, rsp_occ_next;
    logic [COUNT_WIDTH-1:0]  rsp_done_reg, rsp_done_next;
    logic                    rsp_empty_reg, rsp_empty_next;

    logic [COUNT_WIDTH-1:0]  limit;
    logic [COUNT_WIDTH-1:0]  drop_n;
    logic [SUM_WIDTH-1:0]    rp_sum;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rp_reg        <= '0;
            wp_reg        <= '0;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rp_reg        <= rp_next;
            wp_reg        <= wp_next;
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        sample_reg     <= sample_next;
        amount_reg     <= amount_next;
        done_reg       <= done_next;
        result_reg     <= result_next;
        empty_reg      <= empty_next;
        rsp_sample_reg <= rsp_sample_next;
        rsp_occ_reg    <= rsp_occ_next;
        rsp_done_reg   <= rsp_done_next;
        rsp_empty_reg  <= rsp_empty_next;
    end

    // Push writes at most one copy; fill with amount zero runs until the FIFO is full.
    assign limit = (srf_op_t'(op_reg) == OP_PUSH) ? COUNT_WIDTH'(1)
                 : ((amount_reg == '0) ? DEPTH_C : amount_reg);

    assign drop_n = (amount_reg < count_reg) ? amount_reg : count_reg;

    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        sample_next     = sample_reg;
        amount_next     = amount_reg;
        rp_next         = rp_reg;
        wp_next         = wp_reg;
        count_next      = count_reg;
        done_next       = done_reg;
        result_next     = result_reg;
        empty_next      = empty_reg;
        rsp_valid_next  = rsp_valid_reg;
        rsp_sample_next = rsp_sample_reg;
        rsp_occ_next    = rsp_occ_reg;
        rsp_done_next   = rsp_done_reg;
        rsp_empty_next  = rsp_empty_reg;
        req.ready       = 1'b0;
        wr_en           = 1'b0;
        wr_addr         = wp_reg;
        wr_data         = sample_reg;
        rd_en           = 1'b0;
        rd_addr         = rp_reg;
        rp_sum          = SUM_WIDTH'(rp_reg) + SUM_WIDTH'(drop_n);

        if (rsp_valid_reg && rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                req.ready = 1'b1;
                if (req.valid)
                begin
                    op_next     = req.operation;
                    sample_next = req.sample_in;
                    amount_next = req.amount;
                    done_next   = '0;
                    result_next = '0;
                    empty_next  = (count_reg == '0);
                    // The oldest entry is fetched for every item; only pop and peek use it.
                    rd_en       = 1'b1;
                    state_next  = ST_EXEC;
                end
            end

            ST_EXEC:
            begin
                state_next = ST_RESULT;
                case (srf_op_t'(op_reg))
                    OP_PUSH, OP_FILL:
                    begin
                        state_next = ST_WRITE;
                    end
                    OP_POP:
                    begin
                        if (!empty_reg)
                        begin
                            result_next = rd_data;
                            rp_next     = (rp_reg == PTR_LAST) ? '0 : rp_reg + PTR_WIDTH'(1);
                            count_next  = count_reg - COUNT_WIDTH'(1);
                            done_next   = COUNT_WIDTH'(1);
                        end
                    end
                    OP_PEEK:
                    begin
                        if (!empty_reg)
                        begin
                            result_next = rd_data;
                        end
                    end
                    OP_DROP:
                    begin
                        if (rp_sum >= DEPTH_S)
                        begin
                            rp_sum = rp_sum - DEPTH_S;
                        end
                        rp_next    = rp_sum[PTR_WIDTH-1:0];
                        count_next = count_reg - drop_n;
                        done_next  = drop_n;
                    end
                    OP_CLEAR:
                    begin
                        done_next  = count_reg;
                        count_next = '0;
                        rp_next    = '0;
                        wp_next    = '0;
                    end
                    default:
                    begin
                    end
                endcase
            end

            ST_WRITE:
            begin
                if ((count_reg < cap_eff) && (done_reg < limit))
                begin
                    wr_en      = 1'b1;
                    wp_next    = (wp_reg == PTR_LAST) ? '0 : wp_reg + PTR_WIDTH'(1);
                    count_next = count_reg + COUNT_WIDTH'(1);
                    done_next  = done_reg + COUNT_WIDTH'(1);
                end
                else
                begin
                    state_next = ST_RESULT;
                end
            end

            ST_RESULT:
            begin
                if (!rsp_valid_reg || rsp.ready)
                begin
                    rsp_valid_next  = 1'b1;
                    rsp_sample_next = result_reg;
                    rsp_occ_next    = count_reg;
                    rsp_done_next   = done_reg;
                    rsp_empty_next  = empty_reg;
                    state_next      = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign rsp.valid       = rsp_valid_reg;
    assign rsp.sample_out  = rsp_sample_reg;
    assign rsp.occupancy   = rsp_occ_reg;
    assign rsp.amount_done = rsp_done_reg;
    assign rsp.was_empty   = rsp_empty_reg;

endmodule

>>> tb/sample_ring_fifo_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for sample_ring_fifo: directed table, then randomized phases.
// Depends on srf_pkg, the srf_req_if / srf_rsp_if / srf_cfg_if interfaces and the RTL.
module sample_ring_fifo_tb;

    import srf_pkg::*;

    // Operation codes the block does not define. They must leave the state alone and
    // report an all-zero result apart from occupancy and the empty flag.
    localparam logic [OP_WIDTH-1:0] OP_RSVD6 = 3'd6;
    localparam logic [OP_WIDTH-1:0] OP_RSVD7 = 3'd7;

    localparam int STORE_DEPTH = STORE_DEPTH_DEF;
    localparam int CNT_W       = 11;
    localparam int SMP_W       = SAMPLE_WIDTH_DEF;

    // Each random phase runs this many defined operations; twelve phases give
    // roughly 1400 items together with the directed table.
    localparam int NUM_PHASES  = 12;
    localparam int PHASE_ITEMS = 112;

    // Capacity per phase. Zero, one, the full depth and the all-ones value (which
    // saturates to the depth) are all in here, mixed with ordinary sizes.
    localparam int PHASE_CAPACITY [NUM_PHASES] =
        '{1024, 16, 2047, 3, 0, 1, 64, 1024, 1500, 7, 512, 2};

    // The slowest legal item is a fill that writes 1024 copies, plus sender gaps and
    // receiver stalls; the limit leaves a wide margin over 1400 such items.
    localparam longint CYCLE_LIMIT = 8_000_000;

    // Results of a read pass through the sequencer and the output register; this covers both.
    localparam int END_QUIET_CYCLES = 10;

    typedef enum int
    {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } idle_mode_t;

    typedef struct packed
    {
        logic [SMP_W-1:0] sample;
        logic [CNT_W-1:0] occupancy;
        logic [CNT_W-1:0] amount_done;
        logic             was_empty;
    } fifo_result_t;

    // One row of the directed table. A row with set_cap loads the capacity register
    // from its amount field instead of sending an item. Rows with check_typed carry
    // an expected result written out by hand; all other rows use the predictor.
    typedef struct packed
    {
        logic             set_cap;
        logic [2:0]       op;
        logic [SMP_W-1:0] sample;
        logic [CNT_W-1:0] amount;
        logic             check_typed;
        logic [SMP_W-1:0] exp_sample;
        logic [CNT_W-1:0] exp_occ;
        logic [CNT_W-1:0] exp_done;
        logic             exp_empty;
    } stim_row_t;

    localparam int NUM_ROWS = 29;

    localparam stim_row_t DIRECTED_ROWS [NUM_ROWS] = '{
        // Every operation but push and fill on an empty FIFO right after reset.
        '{1'b0, OP_POP,   32'h0000_0000, 11'd0,    1'b1, 32'h0000_0000, 11'd0,    11'd0,    1'b1},
        '{1'b0, OP_PEEK,  32'h0000_0000, 11'd0,    1'b1, 32'h0000_0000, 11'd0,    11'd0,    1'b1},
        '{1'b0, OP_DROP,  32'h0000_0000, 11'd5,    1'b1, 32'h0000_0000, 11'd0,    11'd0,    1'b1},
        '{1'b0, OP_CLEAR, 32'h0000_0000, 11'd0,    1'b1, 32'h0000_0000, 11'd0,    11'd0,    1'b1},
        '{1'b0, OP_RSVD6, 32'hFFFF_FFFF, 11'd2047, 1'b1, 32'h0000_0000, 11'd0,    11'd0,    1'b1},
        '{1'b0, OP_RSVD7, 32'hFFFF_FFFF, 11'd2047, 1'b1, 32'h0000_0000, 11'd0,    11'd0,    1'b1},
        // Extreme sample words in and out again.
        '{1'b0, OP_PUSH,  32'hFFFF_FFFF, 11'd0,    1'b1, 32'h0000_0000, 11'd1,    11'd1,    1'b1},
        '{1'b0, OP_PUSH,  32'h0000_0000, 11'd0,    1'b1, 32'h0000_0000, 11'd2,    11'd1,    1'b0},
        '{1'b0, OP_PEEK,  32'h0000_0000, 11'd0,    1'b1, 32'hFFFF_FFFF, 11'd2,    11'd0,    1'b0},
        '{1'b0, OP_POP,   32'h0000_0000, 11'd0,    1'b1, 32'hFFFF_FFFF, 11'd1,    11'd1,    1'b0},
        // Fill far past the room that is left, then try to write into a full FIFO.
        '{1'b0, OP_FILL,  32'h5A5A_5A5A, 11'd2047, 1'b1, 32'h0000_0000, 11'd1024, 11'd1023, 1'b0},
        '{1'b0, OP_PUSH,  32'h1234_5678, 11'd0,    1'b1, 32'h0000_0000, 11'd1024, 11'd0,    1'b0},
        '{1'b0, OP_POP,   32'h0000_0000, 11'd0,    1'b1, 32'h0000_0000, 11'd1023, 11'd1,    1'b0},
        // Drop more than is held, then fill until full across the pointer wrap.
        '{1'b0, OP_DROP,  32'h0000_0000, 11'd2047, 1'b1, 32'h0000_0000, 11'd0,    11'd1023, 1'b0},
        '{1'b0, OP_FILL,  32'hA5A5_A5A5, 11'd0,    1'b1, 32'h0000_0000, 11'd1024, 11'd1024, 1'b1},
        '{1'b0, OP_CLEAR, 32'h0000_0000, 11'd0,    1'b1, 32'h0000_0000, 11'd0,    11'd1024, 1'b0},
        // A capacity of zero refuses every write.
        '{1'b1, OP_PUSH,  32'h0000_0000, 11'd0,    1'b0, 32'h0000_0000, 11'd0,    11'd0,    1'b0},
        '{1'b0, OP_PUSH,  32'hFFFF_FFFF, 11'd0,    1'b1, 32'h0000_0000, 11'd0,    11'd0,    1'b1},
        '{1'b0, OP_FILL,  32'hFFFF_FFFF, 11'd0,    1'b1, 32'h0000_0000, 11'd0,    11'd0,    1'b1},
        // An oversized capacity behaves as the full depth.
        '{1'b1, OP_PUSH,  32'h0000_0000, 11'd2047, 1'b0, 32'h0000_0000, 11'd0,    11'd0,    1'b0},
        '{1'b0, OP_FILL,  32'h0F0F_0F0F, 11'd3,    1'b0, 32'h0000_0000, 11'd0,    11'd0,    1'b0},
        // Capacity lowered below the occupancy: contents stay, writes are refused.
        '{1'b1, OP_PUSH,  32'h0000_0000, 11'd1,    1'b0, 32'h0000_0000, 11'd0,    11'd0,    1'b0},
        '{1'b0, OP_PUSH,  32'hC3C3_C3C3, 11'd0,    1'b1, 32'h0000_0000, 11'd3,    11'd0,    1'b0},
        '{1'b0, OP_POP,   32'h0000_0000, 11'd0,    1'b0, 32'h0000_0000, 11'd0,    11'd0,    1'b0},
        '{1'b0, OP_DROP,  32'h0000_0000, 11'd1,    1'b0, 32'h0000_0000, 11'd0,    11'd0,    1'b0},
        '{1'b0, OP_POP,   32'h0000_0000, 11'd0,    1'b0, 32'h0000_0000, 11'd0,    11'd0,    1'b0},
        '{1'b0, OP_PUSH,  32'hDEAD_BEEF, 11'd0,    1'b1, 32'h0000_0000, 11'd1,    11'd1,    1'b1},
        '{1'b0, OP_FILL,  32'h0000_0001, 11'd1024, 1'b1, 32'h0000_0000, 11'd1,    11'd0,    1'b0},
        '{1'b0, OP_CLEAR, 32'h0000_0000, 11'd0,    1'b1, 32'h0000_0000, 11'd0,    11'd1,    1'b0}
    };

    logic clk;
    logic rst_n;

    srf_req_if req_ch ();
    srf_rsp_if rsp_ch ();
    srf_cfg_if cfg_ch ();

    sample_ring_fifo dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch),
        .cfg   (cfg_ch)
    );

    // Shadow copy of the FIFO that the predictor keeps in step with the block.
    logic [SMP_W-1:0] shadow_mem [STORE_DEPTH];
    int unsigned      shadow_rd;
    int unsigned      shadow_wr;
    int unsigned      shadow_count;
    int unsigned      shadow_cap;

    // Results owed by the block, oldest first.
    fifo_result_t pending_results [$];

    int     send_idle_pct;
    int     stall_pct;
    int     mismatch_count;
    int     results_checked;
    int     items_sent;
    int     capacity_writes;
    longint cycle_count;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Works out the result of one item and moves the shadow state on. Writes stop
    // at the effective capacity, which is the register value saturated at the depth.
    function automatic fifo_result_t predict_fifo_result(logic [2:0] op,
                                                         logic [SMP_W-1:0] sample,
                                                         logic [CNT_W-1:0] amount);
        fifo_result_t res;
        int unsigned  room_cap;
        int unsigned  limit;
        int unsigned  done;
        bit           empty;

        res      = '0;
        done     = 0;
        empty    = (shadow_count == 0);
        room_cap = (shadow_cap > STORE_DEPTH) ? STORE_DEPTH : shadow_cap;

        case (op)
            OP_PUSH, OP_FILL:
            begin
                if (op == OP_PUSH)
                    limit = 1;
                else
                    limit = (amount == 0) ? STORE_DEPTH : amount;
                while (shadow_count < room_cap && done < limit)
                begin
                    shadow_mem[shadow_wr] = sample;
                    shadow_wr    = (shadow_wr + 1) % STORE_DEPTH;
                    shadow_count = shadow_count + 1;
                    done         = done + 1;
                end
            end
            OP_POP:
            begin
                if (!empty)
                begin
                    res.sample   = shadow_mem[shadow_rd];
                    shadow_rd    = (shadow_rd + 1) % STORE_DEPTH;
                    shadow_count = shadow_count - 1;
                    done         = 1;
                end
            end
            OP_DROP:
            begin
                done         = (amount < shadow_count) ? amount : shadow_count;
                shadow_rd    = (shadow_rd + done) % STORE_DEPTH;
                shadow_count = shadow_count - done;
            end
            OP_PEEK:
            begin
                if (!empty)
                    res.sample = shadow_mem[shadow_rd];
            end
            OP_CLEAR:
            begin
                done         = shadow_count;
                shadow_count = 0;
                shadow_rd    = 0;
                shadow_wr    = 0;
            end
            default:
            begin
            end
        endcase

        res.occupancy   = shadow_count[CNT_W-1:0];
        res.amount_done = done[CNT_W-1:0];
        res.was_empty   = empty;
        return res;
    endfunction

    // Picks a random item. Pushes slightly outnumber pops so that the occupancy
    // climbs and the full condition is reached; fills are short most of the time,
    // with the occasional fill-until-full and the odd random amount.
    function automatic void draw_random_item(output logic [2:0] op,
                                             output logic [SMP_W-1:0] sample,
                                             output logic [CNT_W-1:0] amount);
        int pick;
        int shape;

        pick   = $urandom_range(0, 99);
        shape  = $urandom_range(0, 9);
        sample = $urandom();
        amount = CNT_W'($urandom_range(0, 4));

        if (pick < 38)
            op = OP_PUSH;
        else if (pick < 44)
        begin
            op = OP_FILL;
            if (shape < 8)
                amount = CNT_W'($urandom_range(1, 6));
            else if (shape == 8)
                amount = '0;
            else
                amount = CNT_W'($urandom_range(0, 2047));
        end
        else if (pick < 72)
            op = OP_POP;
        else if (pick < 80)
        begin
            op = OP_DROP;
            if (shape == 0)
                amount = CNT_W'($urandom_range(0, 2047));
        end
        else if (pick < 94)
            op = OP_PEEK;
        else if (pick < 97)
            op = OP_CLEAR;
        else
            op = ($urandom_range(0, 1) != 0) ? OP_RSVD7 : OP_RSVD6;
    endfunction

    task automatic set_idle_mode(idle_mode_t mode);
        case (mode)
            IDLE_NONE:
            begin
                send_idle_pct = 0;
                stall_pct     = 0;
            end
            IDLE_SENDER:
            begin
                send_idle_pct = 56;
                stall_pct     = 0;
            end
            IDLE_RECEIVER:
            begin
                send_idle_pct = 0;
                stall_pct     = 56;
            end
            default:
            begin
                send_idle_pct = 33;
                stall_pct     = 33;
            end
        endcase
    endtask

    // Presents one item and waits for the handshake. The task is entered just after a rising
    // edge or at a falling edge; valid only changes at falling edges, so back-to-back items
    // keep valid high without a glitch. The expectation is queued at acceptance.
    task automatic send_item(logic [2:0] op, logic [SMP_W-1:0] sample,
                             logic [CNT_W-1:0] amount, bit use_typed,
                             fifo_result_t typed_result);
        fifo_result_t predicted;

        @(negedge clk);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            req_ch.valid = 1'b0;
            @(negedge clk);
        end
        req_ch.valid     = 1'b1;
        req_ch.operation = op;
        req_ch.sample_in = sample;
        req_ch.amount    = amount;
        do
            @(posedge clk);
        while (!req_ch.ready);

        // The predictor runs for typed rows too, so the shadow state stays current.
        predicted = predict_fifo_result(op, sample, amount);
        pending_results.push_back(use_typed ? typed_result : predicted);
        items_sent = items_sent + 1;
    endtask

    // Holds the request channel idle until every owed result has been received.
    // Returns at a falling edge.
    task automatic wait_for_results();
        @(negedge clk);
        req_ch.valid = 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
    endtask

    // Loads the capacity register; only called while the block is idle.
    task automatic write_capacity(int unsigned value);
        cfg_ch.valid    = 1'b1;
        cfg_ch.capacity = value[CNT_W-1:0];
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        shadow_cap      = value[CNT_W-1:0];
        capacity_writes = capacity_writes + 1;
        @(negedge clk);
        cfg_ch.valid = 1'b0;
    endtask

    // Receiver side: ready is redrawn at every falling edge from the stall rate.
    initial
    begin
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            rsp_ch.ready = ($urandom_range(0, 99) >= stall_pct);
        end
    end

    // Result checker: every accepted result is compared with the oldest expectation.
    always @(posedge clk)
    begin : result_check
        fifo_result_t got;
        fifo_result_t want;

        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            got.sample      = rsp_ch.sample_out;
            got.occupancy   = rsp_ch.occupancy;
            got.amount_done = rsp_ch.amount_done;
            got.was_empty   = rsp_ch.was_empty;
            if (pending_results.size() == 0)
            begin
                mismatch_count = mismatch_count + 1;
                if (mismatch_count <= 10)
                    $display("Unexpected result: sample %h occupancy %0d done %0d empty %0b",
                             got.sample, got.occupancy, got.amount_done, got.was_empty);
            end
            else
            begin
                want = pending_results.pop_front();
                results_checked = results_checked + 1;
                if (got.sample !== want.sample || got.occupancy !== want.occupancy ||
                    got.amount_done !== want.amount_done || got.was_empty !== want.was_empty)
                begin
                    mismatch_count = mismatch_count + 1;
                    if (mismatch_count <= 10)
                    begin
                        $display("Result %0d: expected sample %h occupancy %0d done %0d empty %0b",
                                 results_checked, want.sample, want.occupancy,
                                 want.amount_done, want.was_empty);
                        $display("           actual   sample %h occupancy %0d done %0d empty %0b",
                                 got.sample, got.occupancy, got.amount_done, got.was_empty);
                    end
                end
            end
        end
    end

    // Watchdog: a hung handshake ends the run here.
    always @(posedge clk)
    begin
        cycle_count = cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles with %0d results outstanding",
                     cycle_count, pending_results.size());
            $display("FAILED: results differ");
            $finish;
        end
    end

    initial
    begin : stimulus
        logic [2:0]       op;
        logic [SMP_W-1:0] sample;
        logic [CNT_W-1:0] amount;
        fifo_result_t     typed_result;
        int               phase_items;
        bit               pause_done;

        // Every input of the block is known from time zero.
        rst_n            = 1'b0;
        req_ch.valid     = 1'b0;
        req_ch.operation = OP_PUSH;
        req_ch.sample_in = '0;
        req_ch.amount    = '0;
        cfg_ch.valid     = 1'b0;
        cfg_ch.capacity  = '0;
        send_idle_pct    = 0;
        stall_pct        = 0;
        mismatch_count   = 0;
        results_checked  = 0;
        items_sent       = 0;
        capacity_writes  = 0;
        cycle_count      = 0;
        shadow_rd        = 0;
        shadow_wr        = 0;
        shadow_count     = 0;
        shadow_cap       = CAPACITY_RESET;

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed table, walked with no idling on either side.
        set_idle_mode(IDLE_NONE);
        for (int row = 0; row < NUM_ROWS; row++)
        begin
            if (DIRECTED_ROWS[row].set_cap)
            begin
                wait_for_results();
                write_capacity(DIRECTED_ROWS[row].amount);
            end
            else
            begin
                typed_result.sample      = DIRECTED_ROWS[row].exp_sample;
                typed_result.occupancy   = DIRECTED_ROWS[row].exp_occ;
                typed_result.amount_done = DIRECTED_ROWS[row].exp_done;
                typed_result.was_empty   = DIRECTED_ROWS[row].exp_empty;
                send_item(DIRECTED_ROWS[row].op, DIRECTED_ROWS[row].sample,
                          DIRECTED_ROWS[row].amount, DIRECTED_ROWS[row].check_typed,
                          typed_result);
            end
        end

        // Random phases. The capacity changes only once the block has gone idle;
        // the occupancy carries over, so a smaller capacity often starts out
        // below the number of samples already held. Halfway through each phase the
        // sender stops until every owed result is back.
        for (int phase = 0; phase < NUM_PHASES; phase++)
        begin
            wait_for_results();
            write_capacity(PHASE_CAPACITY[phase]);
            set_idle_mode(idle_mode_t'(phase % 4));
            phase_items = 0;
            pause_done  = 1'b0;
            while (phase_items < PHASE_ITEMS)
            begin
                if (!pause_done && phase_items == PHASE_ITEMS / 2)
                begin
                    wait_for_results();
                    pause_done = 1'b1;
                end
                draw_random_item(op, sample, amount);
                send_item(op, sample, amount, 1'b0, '0);
                // Reserved codes are ignored by the block and do not count.
                if (op <= OP_CLEAR)
                    phase_items = phase_items + 1;
            end
        end

        // Drain, then stay quiet long enough to catch a stray extra result.
        wait_for_results();
        repeat (END_QUIET_CYCLES) @(posedge clk);

        $display("Sent %0d items over %0d capacity settings and %0d idling patterns;",
                 items_sent, capacity_writes, 4);
        $display("checked %0d results, %0d of them wrong.", results_checked, mismatch_count);
        if (mismatch_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
